[hdl/rtkd_pkg.sv]
// Shared types and constants for the rapid trigger key detector.
// Used by every module in hdl/; depends on nothing else.
package rtkd_pkg;

   localparam int SAMPLE_BITS   = 12;
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((SAMPLE_BITS + 1 + 7) / 8) * 8;
   localparam int CSR_IDX_BITS  = 3;

   typedef logic [SAMPLE_BITS-1:0] level_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_REST_LEVEL    = 3'd0,
      CSR_ACTIVE_LOW    = 3'd1,
      CSR_PRESS_THRESH  = 3'd2,
      CSR_RELEASE_THRESH = 3'd3,
      CSR_RAPID_OFFSET  = 3'd4
   } csr_index_type;

   typedef struct packed {
      level_type rest_level;
      logic      active_low;
      level_type press_threshold;
      level_type release_threshold;
      level_type rapid_offset;
   } cfg_type;

endpackage

[hdl/rapid_trigger_key_detector.sv]
// Rapid trigger key detector, top level.
// Depends on rtkd_pkg, rtkd_csr, rtkd_travel and rtkd_decide.
//
// Usage:
//   req_* carries one raw sensor sample per word; rsp_* returns one word per
//   sample with the pressed state and the computed travel. csr_* writes the
//   rest level, polarity, press and release thresholds and rapid offset by
//   index; write it only while no sample is in flight. csr_ready is always high.
//   A word accepted on req is held in the travel register, moves to the result
//   register when the decision stage takes it and shows on rsp_tvalid
//   from the result register. Throughput is one word per cycle while rsp_tready
//   stays high, limited by the state update in the decision stage.
//   A stalled rsp_tready holds the result register; the travel register
//   still takes one word if it is empty, then req_tready drops until rsp drains.
//   Reset zeroes the configuration and key state and empties both stages; the
//   first sample afterward primes the anchor and always reports key up.
module rapid_trigger_key_detector (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [rtkd_pkg::REQ_DATA_BITS-1:0]        req_tdata,  // [11:0] sample
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [rtkd_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,  // [0] key_down, [12:1] key_travel
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [rtkd_pkg::CSR_IDX_BITS-1:0]         csr_index,
   input  logic [rtkd_pkg::SAMPLE_BITS-1:0]          csr_data
);
   import rtkd_pkg::*;

   cfg_type   cfg;
   logic      mid_valid;
   logic      mid_ready;
   level_type mid_travel;
   logic      key_down;
   level_type key_travel;

   rtkd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rtkd_travel u_travel (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .sample    (req_tdata[SAMPLE_BITS-1:0]),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .travel    (mid_travel)
   );

   rtkd_decide u_decide (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (mid_valid),
      .in_ready   (mid_ready),
      .travel     (mid_travel),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .key_down   (key_down),
      .key_travel (key_travel)
   );

   always_comb begin
      rsp_tdata                  = '0;
      rsp_tdata[0]               = key_down;
      rsp_tdata[SAMPLE_BITS:1]   = key_travel;
   end

endmodule

[hdl/rtkd_csr.sv]
// Configuration registers of the rapid trigger key detector.
// Depends on rtkd_pkg; feeds the travel and decision stages.
module rtkd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rtkd_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [rtkd_pkg::SAMPLE_BITS-1:0]    csr_data,
   output rtkd_pkg::cfg_type                   cfg
);
   import rtkd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_REST_LEVEL:     cfg_in.rest_level        = csr_data;
            CSR_ACTIVE_LOW:     cfg_in.active_low        = csr_data[0];
            CSR_PRESS_THRESH:   cfg_in.press_threshold   = csr_data;
            CSR_RELEASE_THRESH: cfg_in.release_threshold = csr_data;
            CSR_RAPID_OFFSET:   cfg_in.rapid_offset      = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hdl/rtkd_travel.sv]
// Input stage: registers each sample word and turns it into key travel.
// Depends on rtkd_pkg.
module rtkd_travel (
   input  logic                             clock,
   input  logic                             reset,
   input  rtkd_pkg::cfg_type                cfg,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [rtkd_pkg::SAMPLE_BITS-1:0] sample,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [rtkd_pkg::SAMPLE_BITS-1:0] travel
);
   import rtkd_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   level_type travel_ff;
   level_type travel_in;
   logic      load;

   assign in_ready  = !valid_ff || out_ready;
   assign load      = in_valid && in_ready;
   assign valid_in  = load || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign travel    = travel_ff;

   // Clamp at zero when the sample sits on the wrong side of rest.
   always_comb begin
      if (cfg.active_low) begin
         travel_in = (cfg.rest_level > sample) ? cfg.rest_level - sample : '0;
      end else begin
         travel_in = (sample > cfg.rest_level) ? sample - cfg.rest_level : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         travel_ff <= travel_in;
      end
   end

endmodule

[hdl/rtkd_decide.sv]
// Decision stage: key state, rapid trigger anchor and the result register.
// Depends on rtkd_pkg.
module rtkd_decide (
   input  logic                             clock,
   input  logic                             reset,
   input  rtkd_pkg::cfg_type                cfg,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [rtkd_pkg::SAMPLE_BITS-1:0] travel,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic                             key_down,
   output logic [rtkd_pkg::SAMPLE_BITS-1:0] key_travel
);
   import rtkd_pkg::*;

   logic      pressed_ff, pressed_in;
   level_type anchor_ff, anchor_in;
   logic      repress_ff, repress_in;
   logic      primed_ff, primed_in;
   logic      valid_ff, valid_in;
   logic      down_ff;
   level_type travel_ff;
   logic      step;
   level_type peak;
   level_type low;
   logic      repress_cur;

   assign in_ready   = !valid_ff || out_ready;
   assign step       = in_valid && in_ready;
   assign valid_in   = step || (valid_ff && !out_ready);
   assign out_valid  = valid_ff;
   assign key_down   = down_ff;
   assign key_travel = travel_ff;

   assign peak        = (travel > anchor_ff) ? travel : anchor_ff;
   assign low         = (travel < anchor_ff) ? travel : anchor_ff;
   assign repress_cur = (travel <= cfg.release_threshold) ? 1'b0 : repress_ff;

   always_comb begin
      pressed_in = pressed_ff;
      anchor_in  = anchor_ff;
      repress_in = repress_ff;
      primed_in  = 1'b1;
      if (!primed_ff) begin
         pressed_in = 1'b0;
         anchor_in  = travel;
         repress_in = 1'b0;
      end else if (cfg.rapid_offset != '0) begin
         if (pressed_ff) begin
            // Release at the threshold or on a rise back from the deepest point.
            if (travel <= cfg.release_threshold || peak - travel >= cfg.rapid_offset) begin
               pressed_in = 1'b0;
               anchor_in  = travel;
               repress_in = travel > cfg.release_threshold;
            end else begin
               anchor_in = peak;
            end
         end else begin
            repress_in = repress_cur;
            anchor_in  = low;
            if (!repress_cur) begin
               if (travel >= cfg.press_threshold) begin
                  pressed_in = 1'b1;
                  anchor_in  = travel;
               end
            end else if (travel >= cfg.press_threshold &&
                         travel - low >= cfg.rapid_offset) begin
               pressed_in = 1'b1;
               anchor_in  = travel;
            end
         end
      end else begin
         if (!pressed_ff && travel >= cfg.press_threshold) begin
            pressed_in = 1'b1;
         end else if (pressed_ff && travel <= cfg.release_threshold) begin
            pressed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff <= 1'b0;
         anchor_ff  <= '0;
         repress_ff <= 1'b0;
         primed_ff  <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (step) begin
            pressed_ff <= pressed_in;
            anchor_ff  <= anchor_in;
            repress_ff <= repress_in;
            primed_ff  <= primed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         down_ff   <= pressed_in;
         travel_ff <= travel;
      end
   end

endmodule
